// File: hw/rtl/mlic_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mlic_pkg: shared types and constants for the magnetometer calibration block
// Field widths, register map, microcode word layout and the step program.
// ----------------------------------------------------------------------------
package mlic_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int COEF_FRAC_BITS = 14;

    localparam int RAW_W   = 16;
    localparam int SCALE_W = 18;
    localparam int ALPHA_W = 17;
    localparam int OFF_W   = 16;
    localparam int ROW_W   = 48;
    localparam int COEF_W  = 16;
    localparam int OUT_W   = 21;
    localparam int LP_W    = 19;
    localparam int D_W     = 20;
    localparam int H_W     = 20;
    localparam int MA_W    = 20;
    localparam int MB_W    = 19;
    localparam int PROD_W  = MA_W + MB_W;
    localparam int ACC_W   = 40;
    localparam int FSH     = 16;

    localparam int STEP_W  = 4;
    localparam int ADDR_W  = 6;
    localparam int DATA_W  = 64;

    localparam logic [ALPHA_W-1:0] ONE_Q16 = ALPHA_W'(65536);

    localparam logic [SCALE_W-1:0]      RST_SCALE = SCALE_W'(102400);
    localparam logic [ALPHA_W-1:0]      RST_ALPHA = ALPHA_W'(65536);
    localparam logic signed [OFF_W-1:0] RST_OFF_X = -16'sd1331;
    localparam logic signed [OFF_W-1:0] RST_OFF_Y = 16'sd5101;
    localparam logic signed [OFF_W-1:0] RST_OFF_Z = 16'sd201;
    localparam logic [ROW_W-1:0]        RST_ROW0  = 48'd730112999598;
    localparam logic [ROW_W-1:0]        RST_ROW1  = 48'd281110919577120;
    localparam logic [ROW_W-1:0]        RST_ROW2  = 48'd73735993032873;

    typedef enum logic [2:0] {
        REG_SCALE = 3'd0,
        REG_ALPHA = 3'd1,
        REG_OFF_X = 3'd2,
        REG_OFF_Y = 3'd3,
        REG_OFF_Z = 3'd4,
        REG_ROW0  = 3'd5,
        REG_ROW1  = 3'd6,
        REG_ROW2  = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [SCALE_W-1:0]      scale;
        logic [ALPHA_W-1:0]      alpha;
        logic signed [OFF_W-1:0] off_x;
        logic signed [OFF_W-1:0] off_y;
        logic signed [OFF_W-1:0] off_z;
        logic [ROW_W-1:0]        row0;
        logic [ROW_W-1:0]        row1;
        logic [ROW_W-1:0]        row2;
    } t_cfg;

    typedef enum logic [1:0] {
        A_RAW  = 2'd0,
        A_DIFF = 2'd1,
        A_H    = 2'd2
    } t_asel;

    typedef enum logic [1:0] {
        B_SCALE = 2'd0,
        B_ALPHA = 2'd1,
        B_COEF  = 2'd2
    } t_bsel;

    typedef enum logic [2:0] {
        WB_NONE = 3'd0,
        WB_X    = 3'd1,
        WB_LP   = 3'd2,
        WB_CLR  = 3'd3,
        WB_ADD  = 3'd4,
        WB_OUT  = 3'd5
    } t_wb;

    typedef enum logic {
        SQ_NEXT = 1'b0,
        SQ_END  = 1'b1
    } t_sq;

    typedef struct packed {
        logic       mul_en;
        t_asel      a_sel;
        logic [1:0] a_idx;
        t_bsel      b_sel;
        logic [1:0] row;
        t_wb        wb;
        logic [1:0] wb_idx;
        t_sq        sq;
    } t_uop;

    function automatic t_uop mk_uop(input logic m, input t_asel a, input logic [1:0] ai,
                                    input t_bsel b, input logic [1:0] r, input t_wb w,
                                    input logic [1:0] wi, input t_sq s);
        t_uop u;
        u.mul_en = m;
        u.a_sel  = a;
        u.a_idx  = ai;
        u.b_sel  = b;
        u.row    = r;
        u.wb     = w;
        u.wb_idx = wi;
        u.sq     = s;
        return u;
    endfunction

    // each step but the last issues one product; each step but the first retires the product of the step before
    function automatic t_uop ucode(input logic [STEP_W-1:0] step);
        t_uop u;
        case (step)
            4'd0:  u = mk_uop(1'b1, A_RAW,  2'd0, B_SCALE, 2'd0, WB_NONE, 2'd0, SQ_NEXT);
            4'd1:  u = mk_uop(1'b1, A_RAW,  2'd1, B_SCALE, 2'd0, WB_X,    2'd0, SQ_NEXT);
            4'd2:  u = mk_uop(1'b1, A_RAW,  2'd2, B_SCALE, 2'd0, WB_X,    2'd1, SQ_NEXT);
            4'd3:  u = mk_uop(1'b1, A_DIFF, 2'd0, B_ALPHA, 2'd0, WB_X,    2'd2, SQ_NEXT);
            4'd4:  u = mk_uop(1'b1, A_DIFF, 2'd1, B_ALPHA, 2'd0, WB_LP,   2'd0, SQ_NEXT);
            4'd5:  u = mk_uop(1'b1, A_DIFF, 2'd2, B_ALPHA, 2'd0, WB_LP,   2'd1, SQ_NEXT);
            4'd6:  u = mk_uop(1'b1, A_H,    2'd0, B_COEF,  2'd0, WB_LP,   2'd2, SQ_NEXT);
            4'd7:  u = mk_uop(1'b1, A_H,    2'd1, B_COEF,  2'd0, WB_CLR,  2'd0, SQ_NEXT);
            4'd8:  u = mk_uop(1'b1, A_H,    2'd2, B_COEF,  2'd0, WB_ADD,  2'd0, SQ_NEXT);
            4'd9:  u = mk_uop(1'b1, A_H,    2'd0, B_COEF,  2'd1, WB_OUT,  2'd0, SQ_NEXT);
            4'd10: u = mk_uop(1'b1, A_H,    2'd1, B_COEF,  2'd1, WB_CLR,  2'd0, SQ_NEXT);
            4'd11: u = mk_uop(1'b1, A_H,    2'd2, B_COEF,  2'd1, WB_ADD,  2'd0, SQ_NEXT);
            4'd12: u = mk_uop(1'b1, A_H,    2'd0, B_COEF,  2'd2, WB_OUT,  2'd1, SQ_NEXT);
            4'd13: u = mk_uop(1'b1, A_H,    2'd1, B_COEF,  2'd2, WB_CLR,  2'd0, SQ_NEXT);
            4'd14: u = mk_uop(1'b1, A_H,    2'd2, B_COEF,  2'd2, WB_ADD,  2'd0, SQ_NEXT);
            4'd15: u = mk_uop(1'b0, A_RAW,  2'd0, B_SCALE, 2'd0, WB_OUT,  2'd2, SQ_END);
            default: u = mk_uop(1'b0, A_RAW, 2'd0, B_SCALE, 2'd0, WB_NONE, 2'd0, SQ_END);
        endcase
        return u;
    endfunction

    // keep the low SAMPLE_BITS bits and sign-extend from the top one
    function automatic logic signed [RAW_W-1:0] sext_sample(input logic [RAW_W-1:0] v);
        logic [RAW_W-1:0]        up;
        logic signed [RAW_W-1:0] s;
        up = v << (RAW_W - SAMPLE_BITS);
        s  = $signed(up) >>> (RAW_W - SAMPLE_BITS);
        return s;
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/mlic_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mlic_datapath: shared-multiplier datapath
// One signed multiplier, product register, accumulator, per-axis filter state
// and the saturating output registers, all steered by the current control word.
// ----------------------------------------------------------------------------
module mlic_datapath (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_load,
    input  wire logic [mlic_pkg::RAW_W-1:0]         i_raw_x,
    input  wire logic [mlic_pkg::RAW_W-1:0]         i_raw_y,
    input  wire logic [mlic_pkg::RAW_W-1:0]         i_raw_z,
    input  wire logic                               i_en,
    input  wire mlic_pkg::t_uop                     i_uop,
    input  wire mlic_pkg::t_cfg                     i_cfg,
    output logic signed [mlic_pkg::OUT_W-1:0]       o_cal_x,
    output logic signed [mlic_pkg::OUT_W-1:0]       o_cal_y,
    output logic signed [mlic_pkg::OUT_W-1:0]       o_cal_z
);
    import mlic_pkg::*;

    localparam int SH_W = ACC_W - COEF_FRAC_BITS;
    localparam int PS_W = PROD_W - FSH;
    localparam logic signed [SH_W-1:0] SH_MAX = SH_W'((2 ** (OUT_W - 1)) - 1);
    localparam logic signed [SH_W-1:0] SH_MIN = -SH_W'(2 ** (OUT_W - 1));

    logic signed [RAW_W-1:0]  r_raw [3];
    logic signed [D_W-1:0]    r_d   [3];
    logic signed [LP_W-1:0]   r_lp  [3];
    logic signed [H_W-1:0]    r_h   [3];
    logic signed [OUT_W-1:0]  r_res [2];
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;

    logic signed [MA_W-1:0]   op_a;
    logic signed [MB_W-1:0]   op_b;
    logic signed [PROD_W-1:0] n_prod;
    logic [ALPHA_W-1:0]       alpha_c;
    logic [ROW_W-1:0]         row_sel;
    logic signed [COEF_W-1:0] coef;
    logic signed [PS_W-1:0]   ps16;
    logic signed [LP_W-1:0]   lp_old;
    logic signed [LP_W-1:0]   n_lp;
    logic signed [OFF_W-1:0]  off_sel;
    logic signed [D_W-1:0]    n_d;
    logic signed [H_W-1:0]    n_h;
    logic signed [ACC_W-1:0]  prod_x;
    logic signed [ACC_W-1:0]  sum;
    logic signed [SH_W-1:0]   sh;
    logic signed [OUT_W-1:0]  sat;

    assign alpha_c = (i_cfg.alpha > ONE_Q16) ? ONE_Q16 : i_cfg.alpha;

    always_comb begin
        case (i_uop.row)
            2'd0:    row_sel = i_cfg.row0;
            2'd1:    row_sel = i_cfg.row1;
            default: row_sel = i_cfg.row2;
        endcase
        case (i_uop.a_idx)
            2'd0:    coef = $signed(row_sel[COEF_W-1:0]);
            2'd1:    coef = $signed(row_sel[2*COEF_W-1:COEF_W]);
            default: coef = $signed(row_sel[3*COEF_W-1:2*COEF_W]);
        endcase
    end

    always_comb begin
        case (i_uop.a_sel)
            A_RAW:   op_a = MA_W'(r_raw[i_uop.a_idx]);
            A_DIFF:  op_a = r_d[i_uop.a_idx];
            A_H:     op_a = r_h[i_uop.a_idx];
            default: op_a = '0;
        endcase
        case (i_uop.b_sel)
            B_SCALE: op_b = $signed({1'b0, i_cfg.scale});
            B_ALPHA: op_b = $signed({{(MB_W-ALPHA_W){1'b0}}, alpha_c});
            B_COEF:  op_b = MB_W'(coef);
            default: op_b = '0;
        endcase
    end

    assign n_prod = op_a * op_b;

    always_comb begin
        case (i_uop.wb_idx)
            2'd0:    off_sel = i_cfg.off_x;
            2'd1:    off_sel = i_cfg.off_y;
            default: off_sel = i_cfg.off_z;
        endcase
    end

    assign ps16   = r_prod[PROD_W-1:FSH];
    assign lp_old = r_lp[i_uop.wb_idx];
    assign n_d    = $signed(ps16[D_W-1:0]) - D_W'(lp_old);
    assign n_lp   = lp_old + $signed(ps16[LP_W-1:0]);
    assign n_h    = H_W'(n_lp) - H_W'(off_sel);
    assign prod_x = ACC_W'(r_prod);
    assign sum    = r_acc + prod_x;
    assign sh     = sum[ACC_W-1:COEF_FRAC_BITS];

    always_comb begin
        if (sh > SH_MAX) begin
            sat = SH_MAX[OUT_W-1:0];
        end else if (sh < SH_MIN) begin
            sat = SH_MIN[OUT_W-1:0];
        end else begin
            sat = sh[OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_raw[0] <= sext_sample(i_raw_x);
            r_raw[1] <= sext_sample(i_raw_y);
            r_raw[2] <= sext_sample(i_raw_z);
        end
        if (i_en) begin
            if (i_uop.mul_en) begin
                r_prod <= n_prod;
            end
            case (i_uop.wb)
                WB_X: begin
                    r_d[i_uop.wb_idx] <= n_d;
                end
                WB_LP: begin
                    r_h[i_uop.wb_idx] <= n_h;
                end
                WB_CLR: begin
                    r_acc <= prod_x;
                end
                WB_ADD: begin
                    r_acc <= sum;
                end
                WB_OUT: begin
                    if (i_uop.wb_idx == 2'd2) begin
                        o_cal_x <= r_res[0];
                        o_cal_y <= r_res[1];
                        o_cal_z <= sat;
                    end else begin
                        r_res[i_uop.wb_idx[0]] <= sat;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // filter state persists between samples and clears at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lp[0] <= '0;
            r_lp[1] <= '0;
            r_lp[2] <= '0;
        end else if (i_en && i_uop.wb == WB_LP) begin
            r_lp[i_uop.wb_idx] <= n_lp;
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/magnetometer_lowpass_iron_calibration_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// magnetometer_lowpass_iron_calibration_top: three-axis magnetometer calibration
// Scale to microtesla, per-axis low-pass, hard-iron offset, soft-iron matrix,
// saturation to 21 bits, run by a sixteen-step microcode program.
// ----------------------------------------------------------------------------
// Each sample runs the whole program from acceptance to result: all fifteen products
// (three scalings, three filter updates, nine matrix terms) go through a single
// 20x19 signed multiplier, one per step, plus a final step that drains the last
// product into the output register. A new sample is accepted only once the
// program has returned to idle, not while an earlier one is still in flight. The
// last step waits while an earlier result has not yet been taken. Registers sit
// at byte address 8*i on the 64-bit configuration port.
module magnetometer_lowpass_iron_calibration_top (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    output logic                                      o_ready,
    input  wire logic signed [mlic_pkg::RAW_W-1:0]    i_raw_x,
    input  wire logic signed [mlic_pkg::RAW_W-1:0]    i_raw_y,
    input  wire logic signed [mlic_pkg::RAW_W-1:0]    i_raw_z,
    output logic                                      o_valid,
    input  wire logic                                 i_ready,
    output logic signed [mlic_pkg::OUT_W-1:0]         o_cal_x,
    output logic signed [mlic_pkg::OUT_W-1:0]         o_cal_y,
    output logic signed [mlic_pkg::OUT_W-1:0]         o_cal_z,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [mlic_pkg::ADDR_W-1:0]          paddr,
    input  wire logic [mlic_pkg::DATA_W-1:0]          pwdata,
    output logic [mlic_pkg::DATA_W-1:0]               prdata,
    output logic                                      pready
);
    import mlic_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_seq;

    t_cfg              r_cfg;
    t_seq              r_state;
    t_seq              n_state;
    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    logic              r_ovalid;
    logic              n_ovalid;

    t_uop              uop;
    t_reg_idx          reg_idx;
    logic              wr;
    logic              load;
    logic              out_free;
    logic              adv;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[ADDR_W-1:3]);
    assign wr      = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.scale <= RST_SCALE;
            r_cfg.alpha <= RST_ALPHA;
            r_cfg.off_x <= RST_OFF_X;
            r_cfg.off_y <= RST_OFF_Y;
            r_cfg.off_z <= RST_OFF_Z;
            r_cfg.row0  <= RST_ROW0;
            r_cfg.row1  <= RST_ROW1;
            r_cfg.row2  <= RST_ROW2;
        end else if (wr) begin
            case (reg_idx)
                REG_SCALE: r_cfg.scale <= pwdata[SCALE_W-1:0];
                REG_ALPHA: r_cfg.alpha <= pwdata[ALPHA_W-1:0];
                REG_OFF_X: r_cfg.off_x <= $signed(pwdata[OFF_W-1:0]);
                REG_OFF_Y: r_cfg.off_y <= $signed(pwdata[OFF_W-1:0]);
                REG_OFF_Z: r_cfg.off_z <= $signed(pwdata[OFF_W-1:0]);
                REG_ROW0:  r_cfg.row0  <= pwdata[ROW_W-1:0];
                REG_ROW1:  r_cfg.row1  <= pwdata[ROW_W-1:0];
                REG_ROW2:  r_cfg.row2  <= pwdata[ROW_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_SCALE: prdata = DATA_W'(r_cfg.scale);
            REG_ALPHA: prdata = DATA_W'(r_cfg.alpha);
            REG_OFF_X: prdata = DATA_W'($unsigned(r_cfg.off_x));
            REG_OFF_Y: prdata = DATA_W'($unsigned(r_cfg.off_y));
            REG_OFF_Z: prdata = DATA_W'($unsigned(r_cfg.off_z));
            REG_ROW0:  prdata = DATA_W'(r_cfg.row0);
            REG_ROW1:  prdata = DATA_W'(r_cfg.row1);
            REG_ROW2:  prdata = DATA_W'(r_cfg.row2);
            default:   prdata = '0;
        endcase
    end

    // sequencer: step counter over the control store
    assign uop      = ucode(r_step);
    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_ovalid;
    assign load     = i_valid && o_ready;
    assign out_free = !r_ovalid || i_ready;
    assign adv      = (r_state == S_RUN) && ((uop.sq == SQ_NEXT) || out_free);

    always_comb begin
        n_state  = r_state;
        n_step   = r_step;
        n_ovalid = r_ovalid && !i_ready;
        case (r_state)
            S_IDLE: begin
                if (load) begin
                    n_state = S_RUN;
                    n_step  = '0;
                end
            end
            S_RUN: begin
                if (adv) begin
                    if (uop.sq == SQ_END) begin
                        n_state  = S_IDLE;
                        n_step   = '0;
                        n_ovalid = 1'b1;
                    end else begin
                        n_step = r_step + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
                n_step  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_step   <= n_step;
            r_ovalid <= n_ovalid;
        end
    end

    mlic_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_raw_x (i_raw_x),
        .i_raw_y (i_raw_y),
        .i_raw_z (i_raw_z),
        .i_en    (adv),
        .i_uop   (uop),
        .i_cfg   (r_cfg),
        .o_cal_x (o_cal_x),
        .o_cal_y (o_cal_y),
        .o_cal_z (o_cal_z)
    );

    a_end_gives_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && uop.sq == SQ_END) |=> r_ovalid)
        else $error("finished program did not present a result beat");

    a_load_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> (r_state == S_RUN && r_step == '0))
        else $error("accepted beat did not start the program at step zero");

    a_idle_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_step == '0))
        else $error("step counter running while idle");

    a_end_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && uop.sq == SQ_END && r_ovalid && !i_ready)
        |=> (r_state == S_RUN && $stable(r_step)))
        else $error("last step retired over an untaken result");

endmodule
`default_nettype wire
